// ----- rtl/lmsf_pkg.sv -----
// Shared constants, item types and sequencer states for the LED matrix scroll framer.
// Used by every module under rtl except lmsf_ram; depends on nothing.
package lmsf_pkg;

    // Geometry of the display chain and the image
    localparam int DISPLAYS      = 3;
    localparam int IMAGE_COLUMNS = 7;
    localparam int CHAIN_CHIPS   = 4;
    localparam int ROWS          = 8;

    // Image store sizing
    localparam int STORE_DEPTH = ROWS * IMAGE_COLUMNS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // Counter and column widths
    localparam int CHIP_W = (CHAIN_CHIPS > 1) ? $clog2(CHAIN_CHIPS) : 1;
    localparam int DISP_W = (DISPLAYS > 1) ? $clog2(DISPLAYS) : 1;
    localparam int COL_W  = 4;

    // Highest byte offset before it wraps; negative means it always wraps
    localparam int OFFSET_MAX = IMAGE_COLUMNS - DISPLAYS - 1;

    // Queue depths
    localparam int CMDQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 4;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

    // Driver register codes
    localparam logic [3:0] INTENSITY_ADDR = 4'd10;

    // Input action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Reset values
    localparam logic [7:0] FRAME_HOLD_RESET = 8'd3;
    localparam logic [3:0] BRIGHT_RESET     = 4'd15;

    // Classified request passed from the front to the back
    typedef struct packed {
        logic       is_tick;
        logic [2:0] row;
        logic [2:0] column;
        logic [7:0] data;
        logic       button;
    } cmd_t;

    // One driver word
    typedef struct packed {
        logic [3:0] address;
        logic [7:0] data;
        logic       latch_after;
        logic       led_on;
        logic       last;
    } word_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_INTENSITY,
        BS_ROWS
    } back_state_t;

endpackage

// ----- rtl/lmsf_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
// Standalone; no package needed.
module lmsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 56
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read two
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- rtl/lmsf_front.sv -----
// Front end: accepts input requests, drops loads outside the image and builds commands.
// Depends on lmsf_pkg.
module lmsf_front
    import lmsf_pkg::*;
(
    input  logic       push,
    output logic       full,
    input  logic       action,
    input  logic [2:0] image_row,
    input  logic [2:0] image_column,
    input  logic [7:0] image_byte,
    input  logic       button_pressed,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_item
);

    logic col_in_range;

    assign full = q_full;

    // Classify: ticks always pass, loads only inside the image
    assign col_in_range = ({1'b0, image_column} < 4'(IMAGE_COLUMNS));
    assign q_push = push && !q_full && ((action == ACT_TICK) || col_in_range);

    always_comb
    begin
        q_item.is_tick = (action == ACT_TICK);
        q_item.row     = image_row;
        q_item.column  = image_column;
        q_item.data    = image_byte;
        q_item.button  = button_pressed;
    end

endmodule

// ----- rtl/lmsf_cmd_queue.sv -----
// Short command queue between the front end and the frame sequencer.
// Depends on lmsf_pkg for cmd_t and the depth.
module lmsf_cmd_queue
    import lmsf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_item,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    cmd_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign full    = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold request payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/lmsf_out_queue.sv -----
// Result queue holding finished driver words until they are popped.
// Depends on lmsf_pkg for word_t and the depth.
module lmsf_out_queue
    import lmsf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  word_t                 push_word,
    input  logic                  pop,
    output logic                  empty,
    output word_t                 head,
    output logic [OUTQ_CNT_W-1:0] count
);

    word_t                 slot_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CNT_W-1:0] count_reg, count_next;
    logic                  do_pop;

    assign empty  = (count_reg == '0);
    assign head   = slot_reg[rd_ptr_reg];
    assign count  = count_reg;
    assign do_pop = pop && !empty;

    // Advance pointers and occupancy; the sequencer never pushes into a full queue
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold word payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ----- rtl/lmsf_back.sv -----
// Back end: executes loads into the image store and sequences the driver words of a frame.
// Depends on lmsf_pkg and instantiates lmsf_ram.
module lmsf_back
    import lmsf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_frame_hold,
    input  logic                  cmd_empty,
    input  cmd_t                  cmd_head,
    output logic                  cmd_pop,
    input  logic [OUTQ_CNT_W-1:0] out_count,
    output logic                  out_push,
    output word_t                 out_word
);

    back_state_t state_reg, state_next;

    // Persistent block state
    logic [7:0] frame_hold_reg;
    logic [3:0] bright_reg, bright_next;
    logic [7:0] frame_cnt_reg, frame_cnt_next;
    logic [2:0] bit_shift_reg, bit_shift_next;
    logic [2:0] byte_off_reg, byte_off_next;
    logic       button_reg, button_next;

    // Word counters
    logic [CHIP_W-1:0] chip_reg, chip_next;
    logic [DISP_W-1:0] disp_reg, disp_next;
    logic [2:0]        row_reg, row_next;

    // Read stage
    logic                s1_valid_reg;
    logic                s1_is_row_reg;
    logic [3:0]          s1_addr_reg;
    logic [7:0]          s1_data_reg;
    logic [2:0]          s1_shift_reg;
    logic                s1_left_zero_reg, s1_right_zero_reg;
    logic                s1_latch_reg, s1_led_reg, s1_last_reg;

    logic                issue;
    logic                can_issue;
    logic                tick_pop;
    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic [STORE_AW-1:0] raddr_l, raddr_r;
    logic [7:0]          rdata_l, rdata_r;
    logic [COL_W-1:0]    col_l, col_r;
    logic                left_out, right_out;
    logic                chip_last, disp_last, row_last, frame_end;
    logic [7:0]          left_byte, right_byte;
    logic [15:0]         pair;

    assign cfg_ready = 1'b1;

    // Flow control: count words in flight against free result slots
    assign can_issue = ({1'b0, out_count} + (OUTQ_CNT_W + 1)'(s1_valid_reg))
                       < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH);

    assign chip_last = (chip_reg == CHIP_W'(CHAIN_CHIPS - 1));
    assign disp_last = (disp_reg == DISP_W'(DISPLAYS - 1));
    assign row_last  = (row_reg == 3'(ROWS - 1));
    assign frame_end = issue && (state_reg == BS_ROWS) && row_last && disp_last;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE:
            begin
                if (!cmd_empty && cmd_head.is_tick)
                begin
                    state_next = BS_INTENSITY;
                end
            end
            BS_INTENSITY:
            begin
                if (issue && chip_last)
                begin
                    state_next = BS_ROWS;
                end
            end
            BS_ROWS:
            begin
                if (frame_end)
                begin
                    state_next = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        cmd_pop = 1'b0;
        issue   = 1'b0;
        unique case (state_reg)
            BS_IDLE:      cmd_pop = !cmd_empty;
            BS_INTENSITY: issue   = can_issue;
            BS_ROWS:      issue   = can_issue;
            default:      cmd_pop = 1'b0;
        endcase
    end

    assign tick_pop  = cmd_pop && cmd_head.is_tick;
    assign ram_we    = cmd_pop && !cmd_head.is_tick;
    assign ram_waddr = STORE_AW'(int'(cmd_head.row) * IMAGE_COLUMNS + int'(cmd_head.column));

    // Window columns and store addresses for the current word
    assign col_l     = COL_W'(disp_reg) + COL_W'(byte_off_reg);
    assign col_r     = col_l + 1'b1;
    assign left_out  = (col_l >= COL_W'(IMAGE_COLUMNS));
    assign right_out = (col_r >= COL_W'(IMAGE_COLUMNS));
    assign raddr_l   = left_out ? '0 :
                       STORE_AW'(int'(row_reg) * IMAGE_COLUMNS + int'(col_l));
    assign raddr_r   = right_out ? '0 :
                       STORE_AW'(int'(row_reg) * IMAGE_COLUMNS + int'(col_r));

    lmsf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_image (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (cmd_head.data),
        .raddr_a (raddr_l),
        .rdata_a (rdata_l),
        .raddr_b (raddr_r),
        .rdata_b (rdata_r)
    );

    // Counters, brightness and scroll position
    always_comb
    begin
        chip_next      = chip_reg;
        disp_next      = disp_reg;
        row_next       = row_reg;
        bright_next    = bright_reg;
        button_next    = button_reg;
        frame_cnt_next = frame_cnt_reg;
        bit_shift_next = bit_shift_reg;
        byte_off_next  = byte_off_reg;

        if (tick_pop)
        begin
            button_next = cmd_head.button;
            chip_next   = '0;
            disp_next   = '0;
            row_next    = '0;
            if (cmd_head.button)
            begin
                bright_next = bright_reg + 1'b1;
            end
        end

        if (issue && (state_reg == BS_INTENSITY))
        begin
            chip_next = chip_last ? '0 : chip_reg + 1'b1;
        end

        if (issue && (state_reg == BS_ROWS))
        begin
            if (disp_last)
            begin
                disp_next = '0;
                row_next  = row_reg + 1'b1;
            end
            else
            begin
                disp_next = disp_reg + 1'b1;
            end
        end

        // When the frame's last word issues, count held frames, then advance the scroll
        if (frame_end)
        begin
            if (frame_cnt_reg < frame_hold_reg)
            begin
                frame_cnt_next = frame_cnt_reg + 1'b1;
            end
            else
            begin
                frame_cnt_next = '0;
                if (bit_shift_reg == 3'd7)
                begin
                    bit_shift_next = '0;
                    if ((OFFSET_MAX < 0) || (int'(byte_off_reg) >= OFFSET_MAX))
                    begin
                        byte_off_next = '0;
                    end
                    else
                    begin
                        byte_off_next = byte_off_reg + 1'b1;
                    end
                end
                else
                begin
                    bit_shift_next = bit_shift_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BS_IDLE;
            frame_hold_reg <= FRAME_HOLD_RESET;
            bright_reg     <= BRIGHT_RESET;
            frame_cnt_reg  <= '0;
            bit_shift_reg  <= '0;
            byte_off_reg   <= '0;
            button_reg     <= 1'b0;
            chip_reg       <= '0;
            disp_reg       <= '0;
            row_reg        <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bright_reg    <= bright_next;
            frame_cnt_reg <= frame_cnt_next;
            bit_shift_reg <= bit_shift_next;
            byte_off_reg  <= byte_off_next;
            button_reg    <= button_next;
            chip_reg      <= chip_next;
            disp_reg      <= disp_next;
            row_reg       <= row_next;
            s1_valid_reg  <= issue;
            if (cfg_valid && cfg_ready)
            begin
                frame_hold_reg <= cfg_frame_hold;
            end
        end
    end

    // Capture word fields alongside the store read
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_is_row_reg     <= (state_reg == BS_ROWS);
            s1_addr_reg       <= (state_reg == BS_ROWS) ? 4'(ROWS - int'(row_reg))
                                                        : INTENSITY_ADDR;
            s1_data_reg       <= {4'b0, bright_reg};
            s1_shift_reg      <= bit_shift_reg;
            s1_left_zero_reg  <= left_out;
            s1_right_zero_reg <= right_out;
            s1_latch_reg      <= (state_reg == BS_ROWS) ? disp_last : chip_last;
            s1_led_reg        <= button_reg;
            s1_last_reg       <= (state_reg == BS_ROWS) && row_last && disp_last;
        end
    end

    // Funnel shift the two adjacent bytes into the window
    assign left_byte  = s1_left_zero_reg ? 8'd0 : rdata_l;
    assign right_byte = s1_right_zero_reg ? 8'd0 : rdata_r;
    assign pair       = {left_byte, right_byte} << s1_shift_reg;

    assign out_push = s1_valid_reg;
    always_comb
    begin
        out_word.address     = s1_addr_reg;
        out_word.data        = s1_is_row_reg ? pair[15:8] : s1_data_reg;
        out_word.latch_after = s1_latch_reg;
        out_word.led_on      = s1_led_reg;
        out_word.last        = s1_last_reg;
    end

    // Credit check keeps the result queue from overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (out_count < OUTQ_CNT_W'(OUTQ_DEPTH)))
        else $error("result queue pushed while full");

    // The frame's last word returns the sequencer to idle
    a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> (state_reg == BS_IDLE))
        else $error("sequencer did not return to idle after last word");

    // Brightness moves only when a frame tick is taken
    a_bright_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !tick_pop |=> $stable(bright_reg))
        else $error("brightness changed outside a frame tick");

    // The image store is written only between frames
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !issue && (state_next == BS_IDLE))
        else $error("image store written during a frame");

endmodule

// ----- rtl/led_matrix_scroll_framer.sv -----
// LED matrix scroll framer: a load request writes one image byte in a sequencer pop; a frame
// tick holds the sequencer and gives 28 driver words after its pop, one per cycle while the
// result queue has room. A tick's first word passes the command queue, the idle pop, the read
// stage and the result queue; the frame word sequencer and its one-word-per-cycle store read set the rate.
// Reset (rst_n, asynchronous, low) empties both queues, sets brightness 15, hold 3,
// scroll position 0; the image store has no reset and must be loaded before it is shown.
module led_matrix_scroll_framer
    import lmsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       action,
    input  logic [2:0] image_row,
    input  logic [2:0] image_column,
    input  logic [7:0] image_byte,
    input  logic       button_pressed,
    output logic       empty,
    input  logic       pop,
    output logic [3:0] reg_address,
    output logic [7:0] reg_data,
    output logic       latch_after,
    output logic       led_on,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_frame_hold
);

    logic                  q_full;
    logic                  q_push;
    cmd_t                  q_item;
    logic                  cmd_empty;
    logic                  cmd_pop;
    cmd_t                  cmd_head;
    logic                  out_push;
    word_t                 out_word;
    word_t                 out_head;
    logic [OUTQ_CNT_W-1:0] out_count;

    lmsf_front u_front (
        .push           (push),
        .full           (full),
        .action         (action),
        .image_row      (image_row),
        .image_column   (image_column),
        .image_byte     (image_byte),
        .button_pressed (button_pressed),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (q_item)
    );

    lmsf_cmd_queue u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (cmd_pop),
        .empty     (cmd_empty),
        .head      (cmd_head)
    );

    lmsf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_frame_hold (cfg_frame_hold),
        .cmd_empty      (cmd_empty),
        .cmd_head       (cmd_head),
        .cmd_pop        (cmd_pop),
        .out_count      (out_count),
        .out_push       (out_push),
        .out_word       (out_word)
    );

    lmsf_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_word (out_word),
        .pop       (pop),
        .empty     (empty),
        .head      (out_head),
        .count     (out_count)
    );

    // Drive result ports from the oldest waiting word
    assign reg_address = out_head.address;
    assign reg_data    = out_head.data;
    assign latch_after = out_head.latch_after;
    assign led_on      = out_head.led_on;
    assign last        = out_head.last;

endmodule
